FILE: rtl/sic_pkg.sv
// Shared types and constants of the strided index converter.
`default_nettype none
package sic_pkg;

  localparam int unsigned HW_DIMS       = 3;
  localparam int unsigned MAX_DIMS      = 3;
  localparam int unsigned COORD_BITS    = 12;
  localparam int unsigned POSITION_BITS = 40;
  localparam int unsigned EXT_BITS      = COORD_BITS + 1;
  localparam int unsigned DIM_LIMIT     = (MAX_DIMS < HW_DIMS) ? MAX_DIMS : HW_DIMS;
  localparam int unsigned ADDR_BITS     = 5;

  // Register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_NUM_DIMS = 3'd0;
  localparam logic [2:0] REG_EXTENT_0 = 3'd1;
  localparam logic [2:0] REG_EXTENT_1 = 3'd2;
  localparam logic [2:0] REG_EXTENT_2 = 3'd3;
  localparam logic [2:0] REG_OFFSET_0 = 3'd4;
  localparam logic [2:0] REG_OFFSET_1 = 3'd5;
  localparam logic [2:0] REG_OFFSET_2 = 3'd6;

  typedef struct packed {
    logic                     kind;
    logic [COORD_BITS-1:0]    in_coord_0;
    logic [COORD_BITS-1:0]    in_coord_1;
    logic [COORD_BITS-1:0]    in_coord_2;
    logic [POSITION_BITS-1:0] in_position;
  } sic_in_t;

  typedef struct packed {
    logic [POSITION_BITS-1:0] out_position;
    logic [COORD_BITS-1:0]    out_coord_0;
    logic [COORD_BITS-1:0]    out_coord_1;
    logic [COORD_BITS-1:0]    out_coord_2;
    logic                     range_error;
  } sic_out_t;

  // Word carried alongside the multiply-add chain
  typedef struct packed {
    logic                                   kind;
    logic [POSITION_BITS-1:0]               pos;
    logic [HW_DIMS-1:0][EXT_BITS-1:0]       sum;
  } sic_hside_t;

  // Word carried alongside the divider chain
  typedef struct packed {
    logic                                   kind;
    logic [POSITION_BITS-1:0]               pos;
    logic [HW_DIMS-2:0][EXT_BITS-1:0]       rem;
  } sic_dside_t;

endpackage
`default_nettype wire

FILE: rtl/sic_mac.sv
// One registered multiply-add step of the coordinate-to-position chain.
`default_nettype none
module sic_mac
  import sic_pkg::*;
#(
  parameter int unsigned ACC_W  = 40,
  parameter int unsigned MUL_W  = 13,
  parameter int unsigned SIDE_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic              use_i,
  input  wire logic [ACC_W-1:0]  acc_i,
  input  wire logic [MUL_W-1:0]  mul_i,
  input  wire logic [MUL_W-1:0]  add_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [ACC_W-1:0]       acc_o,
  output logic [SIDE_W-1:0]      side_o
);

  logic [ACC_W+MUL_W-1:0] prod;
  logic [ACC_W-1:0]       acc_d, acc_q;
  logic [SIDE_W-1:0]      side_q;
  logic                   valid_q;

  // Scale the running position and add this dimension
  always_comb begin
    prod  = acc_i * mul_i;
    acc_d = use_i ? (prod[ACC_W-1:0] + ACC_W'(add_i)) : acc_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q  <= acc_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign acc_o   = acc_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire

FILE: rtl/sic_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module sic_divider
  import sic_pkg::*;
#(
  parameter int unsigned DVD_W  = 40,
  parameter int unsigned DVS_W  = 13,
  parameter int unsigned SIDE_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [DVD_W-1:0]  dividend_i,
  input  wire logic [DVS_W-1:0]  divisor_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [DVD_W-1:0]       quotient_o,
  output logic [DVS_W-1:0]       remainder_o,
  output logic [SIDE_W-1:0]      side_o
);

  logic [DVD_W:0]             vld;
  logic [DVD_W:0][DVD_W-1:0]  num;
  logic [DVD_W:0][DVS_W-1:0]  rem;
  logic [DVD_W:0][SIDE_W-1:0] side;

  assign vld[0]  = valid_i;
  assign num[0]  = dividend_i;
  assign rem[0]  = '0;
  assign side[0] = side_i;

  for (genvar j = 0; j < DVD_W; j++) begin : g_stage
    logic [DVS_W:0]   trial;
    logic             ge;
    logic [DVS_W:0]   diff;
    logic [DVS_W-1:0] rem_d, rem_q;
    logic [DVD_W-1:0] num_d, num_q;
    logic [SIDE_W-1:0] side_q;
    logic             vld_q;

    // Shift in the next dividend bit and subtract when it fits
    always_comb begin
      trial = {rem[j], num[j][DVD_W-1]};
      ge    = (trial >= {1'b0, divisor_i});
      diff  = trial - {1'b0, divisor_i};
      rem_d = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      num_d = {num[j][DVD_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_d;
        num_q  <= num_d;
        side_q <= side[j];
      end
    end

    assign vld[j+1]  = vld_q;
    assign num[j+1]  = num_q;
    assign rem[j+1]  = rem_q;
    assign side[j+1] = side_q;
  end

  assign valid_o     = vld[DVD_W];
  assign quotient_o  = num[DVD_W];
  assign remainder_o = rem[DVD_W];
  assign side_o      = side[DVD_W];

endmodule
`default_nettype wire

FILE: rtl/strided_index_converter.sv
// Top level of the strided index converter: config registers and pipeline.
//
// Converts row-major view coordinates to a linear position (kind 0) or a
// linear position to view coordinates (kind 1). Configure num_dims, the
// extents and the view offsets over the APB port while no word is in
// flight; reads return the register values.
// Input words enter on in_valid_i / in_stall_o, results leave on
// out_valid_o / out_stall_i; a word moves when valid is high and stall low.
// One word is accepted every cycle unless stalled. The pipeline has two
// multiply-add stages for kind 0, then two chained dividers of 40 stages
// each (one quotient bit per stage, dividing by the extents from the last
// dimension inward), then the output register that forms coordinates and
// range_error. Both kinds travel the full pipeline, so results keep input order.
// When the receiver stalls, the whole pipeline holds; a new word is still
// taken while the output register is empty.
// Reset empties the pipeline and sets num_dims 2, extents 1, offsets 0.
`default_nettype none
module strided_index_converter
  import sic_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire sic_in_t              in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output sic_out_t                  out_data_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int unsigned HSIDE_W = $bits(sic_hside_t);
  localparam int unsigned DSIDE_W = $bits(sic_dside_t);
  localparam logic [POSITION_BITS-1:0] COORD_MAX = POSITION_BITS'((1 << COORD_BITS) - 1);

  // Configuration registers
  logic [1:0]                        num_dims_q;
  logic [HW_DIMS-1:0][EXT_BITS-1:0]  extent_q;
  logic [HW_DIMS-1:0][COORD_BITS-1:0] offset_q;
  logic                              wr_en;
  logic [2:0]                        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q <= 2'd2;
      for (int i = 0; i < HW_DIMS; i++) begin
        extent_q[i] <= EXT_BITS'(1);
        offset_q[i] <= '0;
      end
    end else if (wr_en) begin
      case (reg_idx)
        REG_NUM_DIMS: num_dims_q  <= pwdata[1:0];
        REG_EXTENT_0: extent_q[0] <= pwdata[EXT_BITS-1:0];
        REG_EXTENT_1: extent_q[1] <= pwdata[EXT_BITS-1:0];
        REG_EXTENT_2: extent_q[2] <= pwdata[EXT_BITS-1:0];
        REG_OFFSET_0: offset_q[0] <= pwdata[COORD_BITS-1:0];
        REG_OFFSET_1: offset_q[1] <= pwdata[COORD_BITS-1:0];
        REG_OFFSET_2: offset_q[2] <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (reg_idx)
      REG_NUM_DIMS: prdata = 32'(num_dims_q);
      REG_EXTENT_0: prdata = 32'(extent_q[0]);
      REG_EXTENT_1: prdata = 32'(extent_q[1]);
      REG_EXTENT_2: prdata = 32'(extent_q[2]);
      REG_OFFSET_0: prdata = 32'(offset_q[0]);
      REG_OFFSET_1: prdata = 32'(offset_q[1]);
      REG_OFFSET_2: prdata = 32'(offset_q[2]);
      default:      prdata = '0;
    endcase
  end

  // Dimensions in use and effective extents
  logic [1:0]                       n_dims;
  logic [HW_DIMS-1:0][EXT_BITS-1:0] ext_eff;

  always_comb begin
    if (num_dims_q == 2'd0) begin
      n_dims = 2'd1;
    end else if (32'(num_dims_q) > DIM_LIMIT) begin
      n_dims = 2'(DIM_LIMIT);
    end else begin
      n_dims = num_dims_q;
    end
    for (int i = 0; i < HW_DIMS; i++) begin
      ext_eff[i] = (extent_q[i] == '0) ? EXT_BITS'(1) : extent_q[i];
    end
  end

  // Pipeline advance: hold everything while a result waits on a stall
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Multiply-add chain (Horner form) for kind 0
  logic [HW_DIMS-1:0]                    h_vld;
  logic [HW_DIMS-1:0][POSITION_BITS-1:0] h_acc;
  sic_hside_t [HW_DIMS-1:0]              h_side;

  assign h_side[0].kind   = in_data_i.kind;
  assign h_side[0].pos    = in_data_i.in_position;
  assign h_side[0].sum[0] = EXT_BITS'(in_data_i.in_coord_0) + EXT_BITS'(offset_q[0]);
  assign h_side[0].sum[1] = EXT_BITS'(in_data_i.in_coord_1) + EXT_BITS'(offset_q[1]);
  assign h_side[0].sum[2] = EXT_BITS'(in_data_i.in_coord_2) + EXT_BITS'(offset_q[2]);
  assign h_vld[0] = in_valid_i;
  assign h_acc[0] = POSITION_BITS'(h_side[0].sum[0]);

  for (genvar k = 1; k < HW_DIMS; k++) begin : g_mac
    logic [HSIDE_W-1:0] side_out;
    logic               use_k;
    assign use_k = (k < 32'(n_dims));
    sic_mac #(
      .ACC_W  (POSITION_BITS),
      .MUL_W  (EXT_BITS),
      .SIDE_W (HSIDE_W)
    ) u_mac (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (h_vld[k-1]),
      .use_i   (use_k),
      .acc_i   (h_acc[k-1]),
      .mul_i   (ext_eff[k]),
      .add_i   (h_side[k-1].sum[k]),
      .side_i  (h_side[k-1]),
      .valid_o (h_vld[k]),
      .acc_o   (h_acc[k]),
      .side_o  (side_out)
    );
    assign h_side[k] = sic_hside_t'(side_out);
  end

  // Divider chain for kind 1, innermost dimension first
  logic [HW_DIMS-1:0]                    d_vld;
  logic [HW_DIMS-1:0][POSITION_BITS-1:0] d_num;
  logic [HW_DIMS-1:0][EXT_BITS-1:0]      d_rem;
  sic_dside_t [HW_DIMS-1:0]              d_side;

  assign d_vld[0] = h_vld[HW_DIMS-1];
  assign d_num[0] = h_side[HW_DIMS-1].pos;
  assign d_rem[0] = '0;
  assign d_side[0].kind = h_side[HW_DIMS-1].kind;
  assign d_side[0].pos  = h_acc[HW_DIMS-1];
  assign d_side[0].rem  = '0;

  for (genvar k = 0; k < HW_DIMS - 1; k++) begin : g_div
    logic [EXT_BITS-1:0] divisor;
    sic_dside_t          side_in;
    logic [DSIDE_W-1:0]  side_out;

    // Divide by the extent of dimension n-1-k, or by one past the used ones
    always_comb begin
      divisor = EXT_BITS'(1);
      for (int i = 0; i < HW_DIMS; i++) begin
        if ((k + 1 < 32'(n_dims)) && (i == 32'(n_dims) - 1 - k)) begin
          divisor = ext_eff[i];
        end
      end
      side_in = d_side[k];
      if (k > 0) begin
        side_in.rem[(k > 0) ? k - 1 : 0] = d_rem[k];
      end
    end

    sic_divider #(
      .DVD_W  (POSITION_BITS),
      .DVS_W  (EXT_BITS),
      .SIDE_W (DSIDE_W)
    ) u_div (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .valid_i     (d_vld[k]),
      .dividend_i  (d_num[k]),
      .divisor_i   (divisor),
      .side_i      (side_in),
      .valid_o     (d_vld[k+1]),
      .quotient_o  (d_num[k+1]),
      .remainder_o (d_rem[k+1]),
      .side_o      (side_out)
    );
    assign d_side[k+1] = sic_dside_t'(side_out);
  end

  // Form coordinates and the range flag
  logic [HW_DIMS-2:0][EXT_BITS-1:0]      rem_all;
  logic [HW_DIMS-1:0][POSITION_BITS-1:0] quo;
  logic [HW_DIMS-1:0][POSITION_BITS-1:0] diff;
  logic [HW_DIMS-1:0][COORD_BITS-1:0]    coord;
  logic                                  err;
  sic_out_t                              out_d, out_q;
  logic                                  out_valid_q;

  always_comb begin
    rem_all                = d_side[HW_DIMS-1].rem;
    rem_all[HW_DIMS-2]     = d_rem[HW_DIMS-1];
    err                    = 1'b0;
    for (int i = 0; i < HW_DIMS; i++) begin
      quo[i] = '0;
      if (i == 0) begin
        quo[i] = d_num[HW_DIMS-1];
      end else begin
        for (int r = 0; r < HW_DIMS - 1; r++) begin
          if (r == 32'(n_dims) - 1 - i) begin
            quo[i] = POSITION_BITS'(rem_all[r]);
          end
        end
      end
      diff[i]  = quo[i] - POSITION_BITS'(offset_q[i]);
      coord[i] = '0;
      if (i < 32'(n_dims)) begin
        coord[i] = diff[i][COORD_BITS-1:0];
        if ((quo[i] < POSITION_BITS'(offset_q[i])) || (diff[i] > COORD_MAX)) begin
          err = 1'b1;
        end
      end
    end
    if (d_side[HW_DIMS-1].kind) begin
      out_d.out_position = '0;
      out_d.out_coord_0  = coord[0];
      out_d.out_coord_1  = coord[1];
      out_d.out_coord_2  = coord[2];
      out_d.range_error  = err;
    end else begin
      out_d              = '0;
      out_d.out_position = d_side[HW_DIMS-1].pos;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d_vld[HW_DIMS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // A range error only comes with a kind 1 result, whose position is zero
  a_err_no_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.range_error |-> out_data_o.out_position == '0)
    else $error("range error reported on a position result");

  // Unused third dimension reads zero
  a_dim2_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (n_dims != 2'd3) |-> out_data_o.out_coord_2 == '0)
    else $error("coordinate of unused dimension 2 not zero");

  // With one dimension, only dimension 0 carries a coordinate
  a_dim1_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (n_dims == 2'd1) |-> out_data_o.out_coord_1 == '0)
    else $error("coordinate of unused dimension 1 not zero");

  // Keep a stalled result valid until it is taken
  a_hold_stalls : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");
`endif

endmodule
`default_nettype wire
